### hw/rtl/ais_pkg.sv
// shared widths, item types, register codes and fixed-point helpers
package ais_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;
    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int SW = 2 * W + 2;

    localparam logic signed [W-1:0]  MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  ONE   = W'(1) << F;
    localparam logic signed [SW-1:0] MAX_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_S = ~MAX_S;

    typedef enum logic [2:0] {
        REG_BLEND_MODE   = 3'd0,
        REG_BLEND_FACTOR = 3'd1,
        REG_GAIN_X       = 3'd2,
        REG_GAIN_Y       = 3'd3,
        REG_GAIN_Z       = 3'd4,
        REG_OUTPUT_SCALE = 3'd5,
        REG_DE_SCALE     = 3'd6,
        REG_DE_OFFSET    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [W-1:0] point_x;
        logic signed [W-1:0] point_y;
        logic signed [W-1:0] point_z;
        logic signed [W-1:0] point_w;
        logic [W-2:0]        radius;
        logic signed [W-1:0] estimate_in;
    } in_t;

    typedef struct packed {
        logic signed [W-1:0] new_x;
        logic signed [W-1:0] new_y;
        logic signed [W-1:0] new_z;
        logic signed [W-1:0] new_w;
        logic signed [W-1:0] estimate_out;
    } out_t;

    // data that rides alongside the reciprocal units
    typedef struct packed {
        logic [3:0][W-1:0] p;
        logic [W-1:0]      e;
        logic              dz;
        logic              rz;
        logic              ez;
        logic              eneg;
    } side_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
        logic signed [W-1:0] r;
        if (x > MAX_S)
            r = MAX_V;
        else if (x < MIN_S)
            r = ~MAX_V;
        else
            r = x[W-1:0];
        return r;
    endfunction

    // floor shift of a product by the fraction bits, then saturate
    function automatic logic signed [W-1:0] shr_sat(input logic signed [2*W-1:0] x);
        logic signed [2*W-1:0] sh;
        sh = x >>> F;
        return sat_w(SW'(sh));
    endfunction

endpackage

### hw/rtl/ais_recip.sv
// pipelined restoring divider: floor(2^NUM_EXP / den), one quotient bit per stage
module ais_recip #(
    parameter int DEN_W   = 64,
    parameter int NUM_EXP = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [DEN_W-1:0]   den,
    output logic [NUM_EXP:0]   quo
);
    localparam int STAGES = NUM_EXP + 1;
    localparam int QW     = NUM_EXP + 1;

    logic [DEN_W-1:0] rem_reg [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];
    logic [QW-1:0]    q_reg   [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QW-1:0]    q_in;
        logic [DEN_W:0]   shifted;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        assign shifted = {rem_in, 1'(i == 0)};
        assign diff    = shifted - {1'b0, den_in};
        assign ge      = shifted >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                den_reg[i] <= den_in;
                q_reg[i]   <= {q_in[QW-2:0], ge};
            end
        end
    end

    assign quo = q_reg[STAGES-1];

`ifndef ASSERT_OFF
    a_rem_first: assert property (@(posedge clk) disable iff (!rst_n)
        $past(en) && den_reg[0] != '0 |-> rem_reg[0] < den_reg[0])
        else $error("first remainder not below divisor");
    a_rem_last: assert property (@(posedge clk) disable iff (!rst_n)
        $past(en) && den_reg[STAGES-1] != '0 |-> rem_reg[STAGES-1] < den_reg[STAGES-1])
        else $error("last remainder not below divisor");
`endif

endmodule

### hw/rtl/ais_delay.sv
// shift line that carries side data and valid bits past the dividers
module ais_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_v,
    input  logic [WIDTH-1:0] in_d,
    output logic             out_v,
    output logic [WIDTH-1:0] out_d
);
    logic [DEPTH-1:0] v_reg;
    logic [WIDTH-1:0] d_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DEPTH-2:0], in_v};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= in_d;
            for (int k = 1; k < DEPTH; k++)
                d_reg[k] <= d_reg[k-1];
        end
    end

    assign out_v = v_reg[DEPTH-1];
    assign out_d = d_reg[DEPTH-1];

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("valid line moved during stall");
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        en && in_v |=> v_reg[0])
        else $error("item lost entering delay line");
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_reg[DEPTH-2] |=> out_v)
        else $error("item lost at end of delay line");
`endif

endmodule

### hw/rtl/add_spherical_inversion.sv
// top level: added spherical inversion of a four-component point
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------
//  in       | in_valid / in_ready   | in_item  (point, radius, estimate)
//  out      | out_valid / out_ready | out_item (new point, estimate)
//  cfg      | cfg_we                | cfg_index, cfg_data
//
// one item per cycle while the output is not stalled; words are Q16.16,
// and the reciprocals come from the bit-per-stage restoring dividers
// reset clears valid bits and loads the register defaults
// a stall at the output freezes every stage at once
module add_spherical_inversion (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ais_pkg::in_t  in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output ais_pkg::out_t out_item,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [ais_pkg::WORD_BITS-1:0] cfg_data
);
    import ais_pkg::*;

    localparam int K   = 3 * F;
    localparam int QW  = K + 1;
    localparam int DWD = 2 * W;
    localparam int DWR = W - 1 + F;
    localparam int DWE = W + F;
    localparam int LAT = K + 1;
    localparam logic [QW-1:0] MAX_Q = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};

    logic                blend_mode_reg;
    logic signed [W-1:0] blend_factor_reg, output_scale_reg;
    logic signed [W-1:0] de_scale_reg, de_offset_reg;
    logic signed [W-1:0] gain_reg [3];

    logic en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg   <= 1'b0;
            blend_factor_reg <= ONE;
            gain_reg[0]      <= ONE;
            gain_reg[1]      <= ONE;
            gain_reg[2]      <= ONE;
            output_scale_reg <= ONE;
            de_scale_reg     <= ONE;
            de_offset_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BLEND_MODE:   blend_mode_reg   <= cfg_data[0];
                REG_BLEND_FACTOR: blend_factor_reg <= cfg_data;
                REG_GAIN_X:       gain_reg[0]      <= cfg_data;
                REG_GAIN_Y:       gain_reg[1]      <= cfg_data;
                REG_GAIN_Z:       gain_reg[2]      <= cfg_data;
                REG_OUTPUT_SCALE: output_scale_reg <= cfg_data;
                REG_DE_SCALE:     de_scale_reg     <= cfg_data;
                REG_DE_OFFSET:    de_offset_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // valid bits
    logic [2:0] fv_reg;
    logic [9:0] bv_reg;
    logic       dl_v;

    assign en        = out_ready || !out_valid;
    assign in_ready  = en;
    assign out_valid = bv_reg[9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
            bv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[1:0], in_valid};
            bv_reg <= {bv_reg[8:0], dl_v};
        end
    end

    // front: squares, sum, divisors
    logic signed [W-1:0] s1_p_reg [4];
    logic [W-2:0]        s1_rad_reg, s2_rad_reg;
    logic signed [W-1:0] s1_e_reg, s2_e_reg;
    logic signed [W-1:0] s2_p_reg [4];
    logic [2*W-1:0]      s2_sq_reg [4];
    logic signed [2*W-1:0] sq_full [4];
    logic [2*W+1:0]      sum_all;
    logic [W-1:0]        e_mag;
    logic [DWD-1:0]      den_d_reg;
    logic [DWR-1:0]      den_r_reg;
    logic [DWE-1:0]      den_e_reg;
    side_t               s3_side_reg;

    for (genvar i = 0; i < 4; i++)
    begin : g_sq
        assign sq_full[i] = s1_p_reg[i] * s1_p_reg[i];
    end

    assign sum_all = (2*W+2)'(s2_sq_reg[0]) + (2*W+2)'(s2_sq_reg[1])
                   + (2*W+2)'(s2_sq_reg[2]) + (2*W+2)'(s2_sq_reg[3]);
    assign e_mag   = s2_e_reg[W-1] ? W'(-s2_e_reg) : s2_e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p_reg[0] <= in_item.point_x;
            s1_p_reg[1] <= in_item.point_y;
            s1_p_reg[2] <= in_item.point_z;
            s1_p_reg[3] <= in_item.point_w;
            s1_rad_reg  <= in_item.radius;
            s1_e_reg    <= in_item.estimate_in;
            for (int i = 0; i < 4; i++)
            begin
                s2_sq_reg[i] <= sq_full[i];
                s2_p_reg[i]  <= s1_p_reg[i];
                s3_side_reg.p[i] <= s2_p_reg[i];
            end
            s2_rad_reg <= s1_rad_reg;
            s2_e_reg   <= s1_e_reg;
            den_d_reg  <= (|sum_all[2*W+1:2*W]) ? '1 : sum_all[2*W-1:0];
            den_r_reg  <= {s2_rad_reg, {F{1'b0}}};
            den_e_reg  <= {e_mag, {F{1'b0}}};
            s3_side_reg.e    <= s2_e_reg;
            s3_side_reg.dz   <= (sum_all == '0);
            s3_side_reg.rz   <= (s2_rad_reg == '0);
            s3_side_reg.ez   <= (s2_e_reg == '0);
            s3_side_reg.eneg <= s2_e_reg[W-1];
        end
    end

    // reciprocals
    logic [QW-1:0] q_d, q_r, q_e;
    side_t         dl_side;

    ais_recip #(.DEN_W(DWD), .NUM_EXP(K)) u_recip_d (
        .clk(clk), .rst_n(rst_n), .en(en), .den(den_d_reg), .quo(q_d));
    ais_recip #(.DEN_W(DWR), .NUM_EXP(K)) u_recip_r (
        .clk(clk), .rst_n(rst_n), .en(en), .den(den_r_reg), .quo(q_r));
    ais_recip #(.DEN_W(DWE), .NUM_EXP(K)) u_recip_e (
        .clk(clk), .rst_n(rst_n), .en(en), .den(den_e_reg), .quo(q_e));

    ais_delay #(.WIDTH($bits(side_t)), .DEPTH(LAT)) u_side (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_v(fv_reg[2]), .in_d(s3_side_reg),
        .out_v(dl_v), .out_d(dl_side));

    // back: blend, gains, scales
    logic [W-1:0]        cd, cr, ce;
    logic [W-1:0]        b1_d_reg, b1_r_reg;
    logic signed [W-1:0] b1_inv_reg;
    logic [3:0][W-1:0]   bp_reg [7];
    logic signed [W-1:0] b1_e_reg;
    logic signed [W:0]   b2_diff_reg;
    logic [W-1:0]        b2_base_reg, b3_base_reg;
    logic signed [W-1:0] b2_esum_reg;
    logic signed [2*W:0] b3_bprod_reg;
    logic signed [2*W-1:0] b3_eprod_reg;
    logic signed [W-1:0] b4_dn_reg, b4_e_reg;
    logic signed [2*W-1:0] b5_gprod_reg [4];
    logic signed [2*W-1:0] b5_eprod_reg;
    logic signed [W-1:0] b6_gd_reg [4];
    logic signed [W-1:0] b6_e_reg, b7_e_reg, b8_e_reg, b9_e_reg;
    logic signed [2*W-1:0] b7_tprod_reg [4];
    logic signed [W-1:0] b8_s_reg [4];
    logic signed [2*W-1:0] b9_oprod_reg [4];
    logic signed [W-1:0] gain_eff [4];
    out_t                out_reg;

    assign cd = (q_d > MAX_Q) ? MAX_V : q_d[W-1:0];
    assign cr = (q_r > MAX_Q) ? MAX_V : q_r[W-1:0];
    assign ce = (q_e > MAX_Q) ? MAX_V : q_e[W-1:0];

    assign gain_eff[0] = gain_reg[0];
    assign gain_eff[1] = gain_reg[1];
    assign gain_eff[2] = gain_reg[2];
    assign gain_eff[3] = ONE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_d_reg   <= dl_side.dz ? MAX_V : cd;
            b1_r_reg   <= dl_side.rz ? MAX_V : cr;
            b1_inv_reg <= dl_side.ez ? MAX_V : (dl_side.eneg ? W'(-ce) : ce);
            b1_e_reg   <= dl_side.e;
            bp_reg[0]  <= dl_side.p;
            for (int k = 1; k < 7; k++)
                bp_reg[k] <= bp_reg[k-1];

            b2_diff_reg <= blend_mode_reg
                ? $signed({1'b0, b1_r_reg}) - $signed({1'b0, b1_d_reg})
                : $signed({1'b0, b1_d_reg}) - $signed({1'b0, b1_r_reg});
            b2_base_reg <= blend_mode_reg ? b1_d_reg : b1_r_reg;
            b2_esum_reg <= sat_w(SW'(b1_e_reg) + SW'(b1_inv_reg));

            b3_bprod_reg <= b2_diff_reg * blend_factor_reg;
            b3_eprod_reg <= b2_esum_reg * output_scale_reg;
            b3_base_reg  <= b2_base_reg;

            b4_dn_reg <= sat_w(SW'($signed({1'b0, b3_base_reg})) + SW'(b3_bprod_reg >>> F));
            b4_e_reg  <= shr_sat(b3_eprod_reg);

            for (int i = 0; i < 4; i++)
                b5_gprod_reg[i] <= gain_eff[i] * b4_dn_reg;
            b5_eprod_reg <= b4_e_reg * de_scale_reg;

            for (int i = 0; i < 4; i++)
                b6_gd_reg[i] <= shr_sat(b5_gprod_reg[i]);
            b6_e_reg <= sat_w(SW'(shr_sat(b5_eprod_reg)) + SW'(de_offset_reg));

            for (int i = 0; i < 4; i++)
                b7_tprod_reg[i] <= $signed(bp_reg[5][i]) * b6_gd_reg[i];
            b7_e_reg <= b6_e_reg;

            for (int i = 0; i < 4; i++)
                b8_s_reg[i] <= sat_w(SW'($signed(bp_reg[6][i]))
                                     + SW'(shr_sat(b7_tprod_reg[i])));
            b8_e_reg <= b7_e_reg;

            for (int i = 0; i < 4; i++)
                b9_oprod_reg[i] <= b8_s_reg[i] * output_scale_reg;
            b9_e_reg <= b8_e_reg;

            out_reg.new_x        <= shr_sat(b9_oprod_reg[0]);
            out_reg.new_y        <= shr_sat(b9_oprod_reg[1]);
            out_reg.new_z        <= shr_sat(b9_oprod_reg[2]);
            out_reg.new_w        <= shr_sat(b9_oprod_reg[3]);
            out_reg.estimate_out <= b9_e_reg;
        end
    end

    assign out_item = out_reg;

`ifndef ASSERT_OFF
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> fv_reg[0])
        else $error("accepted item missing in first stage");
    a_rz: assert property (@(posedge clk) disable iff (!rst_n)
        fv_reg[2] && s3_side_reg.rz |-> den_r_reg == '0)
        else $error("zero radius flag disagrees with divisor");
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        bv_reg[0] && $past(en) && $past(dl_side.dz) |-> b1_d_reg == MAX_V)
        else $error("zero point did not saturate reciprocal");
`endif

endmodule

### test/add_spherical_inversion_tb.sv
// testbench for add_spherical_inversion: directed table and random items against a predictor
module add_spherical_inversion_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ais_pkg::*;

    localparam int LATENCY = 3 * FRACTION_BITS + 14;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1250;
    localparam logic [63:0] MAXV64 = 64'h7fffffff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_item;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [W-1:0] cfg_data = '0;

    add_spherical_inversion dut (.*);

    always #1 clk = ~clk;

    // predictor copy of the registers
    logic mode_q;
    logic signed [63:0] factor_q, gx_q, gy_q, gz_q, oscale_q, dscale_q, doffset_q;

    out_t expected_q[$];
    int failures = 0;
    int idle_pct = 38;
    int quiet_cycles = 0;

    typedef struct {
        in_t item;
        bit has_exp;
        out_t exp;
    } row_t;

    function automatic logic signed [63:0] clamp(input logic signed [63:0] x);
        if (x > $signed(MAXV64)) return $signed(MAXV64);
        if (x < -$signed(MAXV64) - 1) return -$signed(MAXV64) - 1;
        return x;
    endfunction

    function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return clamp(p >>> F);
    endfunction

    function automatic logic [63:0] pow2_div(input int k, input logic [63:0] den);
        logic [127:0] num;
        logic [127:0] q;
        num = 128'd1 << k;
        q = num / {64'd0, den};
        return (q > {64'd0, MAXV64}) ? MAXV64 : q[63:0];
    endfunction

    function automatic out_t inversion_result(input in_t it);
        logic signed [63:0] p[4], g[4], d, r, e, inv, gd, t, v;
        logic [64:0] acc;
        logic [63:0] sq, rad;
        out_t o;
        p[0] = it.point_x; p[1] = it.point_y; p[2] = it.point_z; p[3] = it.point_w;
        acc = 0;
        for (int i = 0; i < 4; i++)
        begin
            sq = p[i] * p[i];
            acc = acc + sq;
            if (acc[64]) acc = {1'b0, 64'hffffffffffffffff};
        end
        rad = {33'd0, it.radius};
        d = (acc == 0) ? MAXV64 : pow2_div(3 * F, acc[63:0]);
        r = (rad == 0) ? MAXV64 : pow2_div(2 * F, rad);
        if (!mode_q)
            d = clamp(r + (((d - r) * factor_q) >>> F));
        else
            d = clamp(d + (((r - d) * factor_q) >>> F));
        g[0] = gx_q; g[1] = gy_q; g[2] = gz_q; g[3] = 64'sd1 <<< F;
        for (int i = 0; i < 4; i++)
        begin
            gd = fix_mul(g[i], d);
            t = fix_mul(p[i], gd);
            v = fix_mul(clamp(p[i] + t), oscale_q);
            case (i)
                0: o.new_x = v[W-1:0];
                1: o.new_y = v[W-1:0];
                2: o.new_z = v[W-1:0];
                default: o.new_w = v[W-1:0];
            endcase
        end
        e = it.estimate_in;
        if (e == 0)
            inv = MAXV64;
        else if (e < 0)
            inv = -$signed(pow2_div(2 * F, -e));
        else
            inv = pow2_div(2 * F, e);
        e = clamp(e + inv);
        e = fix_mul(e, oscale_q);
        e = clamp(fix_mul(e, dscale_q) + doffset_q);
        o.estimate_out = e[W-1:0];
        return o;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BLEND_MODE:   mode_q = val[0];
            REG_BLEND_FACTOR: factor_q = $signed(val);
            REG_GAIN_X:       gx_q = $signed(val);
            REG_GAIN_Y:       gy_q = $signed(val);
            REG_GAIN_Z:       gz_q = $signed(val);
            REG_OUTPUT_SCALE: oscale_q = $signed(val);
            REG_DE_SCALE:     dscale_q = $signed(val);
            default:          doffset_q = $signed(val);
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // drives one item at the falling edge and holds it until accepted
    task automatic send_item(input in_t it, input bit has_exp, input out_t exp);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(has_exp ? exp : inversion_result(it));
        @(negedge clk);
    endtask

    function automatic logic [W-1:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom_range(3) << F;
            1: return -($urandom_range(3) << F);
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            3: return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t rand_item();
        in_t it;
        logic [W-1:0] rw;
        it.point_x = rand_word();
        it.point_y = rand_word();
        it.point_z = rand_word();
        it.point_w = rand_word();
        rw = rand_word();
        it.radius = rw[W-2:0];
        it.estimate_in = rand_word();
        return it;
    endfunction

    task automatic random_config();
        write_reg(REG_BLEND_MODE, $urandom_range(1));
        write_reg(REG_BLEND_FACTOR, $urandom_range(1) ? rand_word() : $urandom_range(65536));
        write_reg(REG_GAIN_X, rand_word());
        write_reg(REG_GAIN_Y, rand_word());
        write_reg(REG_GAIN_Z, rand_word());
        write_reg(REG_OUTPUT_SCALE, $urandom_range(1) ? rand_word() : 32'h10000);
        write_reg(REG_DE_SCALE, rand_word());
        write_reg(REG_DE_OFFSET, rand_word());
    endtask

    // output checking and stall generation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected item %h", out_item);
                failures++;
            end
            else
            begin
                out_t x;
                x = expected_q.pop_front();
                if (x.new_x !== out_item.new_x)
                begin $error("new_x exp %h got %h", x.new_x, out_item.new_x); failures++; end
                if (x.new_y !== out_item.new_y)
                begin $error("new_y exp %h got %h", x.new_y, out_item.new_y); failures++; end
                if (x.new_z !== out_item.new_z)
                begin $error("new_z exp %h got %h", x.new_z, out_item.new_z); failures++; end
                if (x.new_w !== out_item.new_w)
                begin $error("new_w exp %h got %h", x.new_w, out_item.new_w); failures++; end
                if (x.estimate_out !== out_item.estimate_out)
                begin
                    $error("estimate_out exp %h got %h", x.estimate_out, out_item.estimate_out);
                    failures++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk)
        out_ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("add_spherical_inversion: mismatch");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        in_t it;
        out_t ex;
        mode_q = 0; factor_q = 65536; gx_q = 65536; gy_q = 65536; gz_q = 65536;
        oscale_q = 65536; dscale_q = 65536; doffset_q = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero point, radius, estimate at reset settings: known saturated result
        it = '0;
        ex = '{new_x: 0, new_y: 0, new_z: 0, new_w: 0, estimate_out: 32'h7fffffff};
        rows.push_back('{it, 1, ex});
        // unit x, unit radius, unit estimate: d=1, r=1 -> x doubles, e = 2.0
        it = '0; it.point_x = ONE; it.radius = (W-1)'(ONE); it.estimate_in = ONE;
        ex = '{new_x: 2 * ONE, new_y: 0, new_z: 0, new_w: 0, estimate_out: 2 * ONE};
        rows.push_back('{it, 1, ex});
        it = '0; it.point_x = 32'h7fffffff; it.point_y = 32'h80000000;
        it.point_z = 32'h7fffffff; it.point_w = 32'h80000000;
        it.radius = 31'h7fffffff; it.estimate_in = 32'h80000000;
        rows.push_back('{it, 0, ex});
        it = '0; it.point_w = -ONE; it.radius = (W-1)'(1); it.estimate_in = -ONE;
        rows.push_back('{it, 0, ex});
        it = '0; it.point_y = 1; it.estimate_in = 1;
        rows.push_back('{it, 0, ex});
        it = '0; it.point_z = -1; it.radius = (W-1)'(ONE / 2); it.estimate_in = -1;
        rows.push_back('{it, 0, ex});
        it = '0; it.point_x = 32'hffffffff; it.point_y = 32'hffffffff;
        it.point_z = 32'hffffffff; it.point_w = 32'hffffffff; it.radius = 31'h7fffffff;
        it.estimate_in = 32'h7fffffff;
        rows.push_back('{it, 0, ex});
        foreach (rows[i])
        begin
            rw = rows[i];
            send_item(rw.item, rw.has_exp, rw.exp);
        end
        wait_drained();

        // extreme settings, then the other blend direction
        write_reg(REG_BLEND_MODE, 1);
        write_reg(REG_BLEND_FACTOR, 32'h80000000);
        write_reg(REG_GAIN_X, 32'h7fffffff);
        write_reg(REG_GAIN_Y, 32'h80000000);
        write_reg(REG_GAIN_Z, 0);
        write_reg(REG_OUTPUT_SCALE, 32'h7fffffff);
        write_reg(REG_DE_SCALE, 32'h80000000);
        write_reg(REG_DE_OFFSET, 32'h7fffffff);
        foreach (rows[i]) send_item(rows[i].item, 0, ex);
        wait_drained();
        write_reg(REG_BLEND_FACTOR, 32'h7fffffff);
        write_reg(REG_OUTPUT_SCALE, 32'h80000000);
        write_reg(REG_DE_OFFSET, 32'h80000000);
        write_reg(REG_BLEND_MODE, 0);
        foreach (rows[i]) send_item(rows[i].item, 0, ex);
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 150 == 0)
            begin
                wait_drained();
                random_config();
            end
            idle_pct = (n >= 600 && n < 800) ? 0 : 38;
            send_item(rand_item(), 0, ex);
        end
        idle_pct = 38;
        wait_drained();
        if (failures == 0)
            $display("add_spherical_inversion: match");
        else
            $display("add_spherical_inversion: mismatch");
        $finish;
    end
endmodule
